@@ src/plch_pkg.sv @@
package plch_pkg;

  localparam int LANES       = 16;
  localparam int BINS        = 1024;
  localparam int CODE_WIDTH  = 16;
  localparam int COUNT_WIDTH = 32;

  // fixed field widths of the channels
  localparam int QUARTER_WIDTH = 64;
  localparam int SEL_WIDTH     = 10;
  localparam int TOTAL_WIDTH   = 36;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_DATA  = 4'b0100,
    ST_READ  = 4'b1000
  } state_t;

endpackage

@@ src/parallel_lane_code_histogram.sv @@
// Multi-lane code histogram. Each lane keeps its own bin counts in a RAM of
// its own (BINS x COUNT_WIDTH, registered read), and all lanes work in
// lockstep. After reset a clearing pass writes zero to every bin, during which
// in_stall stays high. In a data word (cmd 0) all lanes read their code's bin,
// then write back the count plus one, saturating; codes of BINS or more are
// skipped and set the sticky range_error flag. In a read word (cmd 1) all
// lanes read the bin, then the lanes are summed in turn through a single
// shared adder, while the bin is zeroed in every lane. Its result sits in an
// output register, so the next word is taken while a result waits; a read
// finishes only once that register is free. A bin_sel of BINS or more returns
// zero, clears nothing.
module parallel_lane_code_histogram #(
  parameter int LANES       = plch_pkg::LANES,
  parameter int BINS        = plch_pkg::BINS,
  parameter int CODE_WIDTH  = plch_pkg::CODE_WIDTH,
  parameter int COUNT_WIDTH = plch_pkg::COUNT_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [plch_pkg::QUARTER_WIDTH-1:0] in_word_q0,
  input  logic [plch_pkg::QUARTER_WIDTH-1:0] in_word_q1,
  input  logic [plch_pkg::QUARTER_WIDTH-1:0] in_word_q2,
  input  logic [plch_pkg::QUARTER_WIDTH-1:0] in_word_q3,
  input  logic [plch_pkg::SEL_WIDTH-1:0]     in_bin_sel,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [plch_pkg::TOTAL_WIDTH-1:0]   out_bin_total,
  output logic                               out_range_error
);

  localparam int AW = $clog2(BINS);
  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int TW = plch_pkg::TOTAL_WIDTH;
  localparam int WW = 4 * plch_pkg::QUARTER_WIDTH;
  localparam logic [AW-1:0] LAST_BIN = AW'(BINS - 1);
  localparam logic [LW-1:0] LAST_LANE = LW'(LANES - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  plch_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic [LW-1:0]  lane_r, lane_nxt;
  logic [TW-1:0]  acc_r, acc_nxt;
  logic           bad_r, bad_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [TW-1:0]  out_total_r, out_total_nxt;
  logic           out_err_r, out_err_nxt;

  logic [WW-1:0]  word;
  logic           accept;
  logic [31:0]    sel_ext;
  logic           sel_ok;
  logic [AW-1:0]  sel_addr;
  logic [TW-1:0]  sum;
  logic           out_free;

  logic [LANES-1:0]       code_ok;
  logic [AW-1:0]          code_addr [LANES];
  logic [AW-1:0]          rd_addr   [LANES];
  logic [COUNT_WIDTH-1:0] rd_data   [LANES];
  logic [AW-1:0]          addr_r    [LANES];
  logic [LANES-1:0]       ok_r;
  logic [LANES-1:0]       wr_en;
  logic [AW-1:0]          wr_addr   [LANES];
  logic [COUNT_WIDTH-1:0] wr_data   [LANES];

  assign word     = {in_word_q3, in_word_q2, in_word_q1, in_word_q0};
  assign in_stall = (state_r != plch_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign sel_ext  = 32'(in_bin_sel);
  assign sel_ok   = (sel_ext < 32'(BINS));
  assign sel_addr = sel_ext[AW-1:0];
  assign out_free = !out_valid_r || !out_stall;

  for (genvar n = 0; n < LANES; n++) begin : g_lane
    logic [CODE_WIDTH-1:0] code;
    logic [31:0]           code_ext;

    assign code         = word[n*CODE_WIDTH +: CODE_WIDTH];
    assign code_ext     = 32'(code);
    assign code_ok[n]   = (code_ext < 32'(BINS));
    assign code_addr[n] = code_ext[AW-1:0];
    assign rd_addr[n]   = (in_cmd == plch_pkg::CMD_READ) ? sel_addr : code_addr[n];

    always_ff @(posedge clk) begin
      if (accept) begin
        addr_r[n] <= rd_addr[n];
        ok_r[n]   <= (in_cmd == plch_pkg::CMD_READ) ? sel_ok : code_ok[n];
      end
    end

    always_comb begin
      wr_en[n]   = 1'b0;
      wr_addr[n] = addr_r[n];
      wr_data[n] = '0;
      case (state_r)
        plch_pkg::ST_CLEAR: begin
          wr_en[n]   = 1'b1;
          wr_addr[n] = clr_addr_r;
        end
        plch_pkg::ST_DATA: begin
          wr_en[n]   = ok_r[n] && (rd_data[n] != COUNT_MAX);
          wr_data[n] = rd_data[n] + 1'b1;
        end
        // zeroing repeats while the read is held; read data stays put
        plch_pkg::ST_READ: wr_en[n] = ok_r[n];
        default: wr_en[n] = 1'b0;
      endcase
    end

    plch_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (BINS)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en[n]),
      .wr_addr (wr_addr[n]),
      .wr_data (wr_data[n]),
      .rd_en   (accept),
      .rd_addr (rd_addr[n]),
      .rd_data (rd_data[n])
    );
  end

  // out-of-range bins add nothing
  assign sum = acc_r + (ok_r[lane_r] ? TW'(rd_data[lane_r]) : TW'(0));

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    lane_nxt      = lane_r;
    acc_nxt       = acc_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r;
    out_total_nxt = out_total_r;
    out_err_nxt   = out_err_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      plch_pkg::ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_BIN) begin
          state_nxt = plch_pkg::ST_IDLE;
        end
      end
      plch_pkg::ST_IDLE: begin
        if (accept) begin
          lane_nxt = '0;
          acc_nxt  = '0;
          if (in_cmd == plch_pkg::CMD_READ) begin
            state_nxt = plch_pkg::ST_READ;
          end else begin
            state_nxt = plch_pkg::ST_DATA;
            if (!(&code_ok)) begin
              bad_nxt = 1'b1;
            end
          end
        end
      end
      plch_pkg::ST_DATA: state_nxt = plch_pkg::ST_IDLE;
      plch_pkg::ST_READ: begin
        if (lane_r != LAST_LANE) begin
          acc_nxt  = sum;
          lane_nxt = lane_r + 1'b1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = sum;
          out_err_nxt   = bad_r;
          state_nxt     = plch_pkg::ST_IDLE;
        end
      end
      default: state_nxt = plch_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plch_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      lane_r      <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      lane_r      <= lane_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    out_total_r <= out_total_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_bin_total   = out_total_r;
  assign out_range_error = out_err_r;

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == plch_pkg::ST_READ))
    else $error("result word appeared without a read");

  a_data_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plch_pkg::ST_DATA) |=> (state_r == plch_pkg::ST_IDLE))
    else $error("data word writeback did not finish in one cycle");

  a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(bad_r))
    else $error("range error flag cleared");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plch_pkg::ST_CLEAR) |=> !$past(accept))
    else $error("word accepted during clearing pass");

endmodule

@@ src/plch_ram.sv @@
module plch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ tb/tb_parallel_lane_code_histogram.sv @@
`timescale 1ns / 100ps

module tb_parallel_lane_code_histogram;

  localparam int LANES         = plch_pkg::LANES;
  localparam int BINS          = plch_pkg::BINS;
  localparam int CODE_WIDTH    = plch_pkg::CODE_WIDTH;
  localparam int COUNT_WIDTH   = plch_pkg::COUNT_WIDTH;
  localparam int QUARTER_WIDTH = plch_pkg::QUARTER_WIDTH;
  localparam int SEL_WIDTH     = plch_pkg::SEL_WIDTH;
  localparam int TOTAL_WIDTH   = plch_pkg::TOTAL_WIDTH;

  localparam int RANDOM_WORDS = 2000;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_cmd;
  logic [QUARTER_WIDTH-1:0] in_word_q0;
  logic [QUARTER_WIDTH-1:0] in_word_q1;
  logic [QUARTER_WIDTH-1:0] in_word_q2;
  logic [QUARTER_WIDTH-1:0] in_word_q3;
  logic [SEL_WIDTH-1:0]     in_bin_sel;
  logic                     out_valid;
  logic                     out_stall;
  logic [TOTAL_WIDTH-1:0]   out_bin_total;
  logic                     out_range_error;

  parallel_lane_code_histogram uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_word_q0      (in_word_q0),
    .in_word_q1      (in_word_q1),
    .in_word_q2      (in_word_q2),
    .in_word_q3      (in_word_q3),
    .in_bin_sel      (in_bin_sel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bin_total   (out_bin_total),
    .out_range_error (out_range_error)
  );

  typedef struct packed {
    logic [TOTAL_WIDTH-1:0] total;
    logic                   err;
  } bin_read_t;

  typedef struct packed {
    logic                   cmd;
    logic [255:0]           word;
    logic [SEL_WIDTH-1:0]   sel;
    bit                     known;
    logic [TOTAL_WIDTH-1:0] total;
    logic                   err;
  } dir_row_t;

  localparam bit KNOWN = 1'b1;
  localparam bit PRED  = 1'b0;

  localparam logic [63:0] Q_TOP  = 64'h03FF_03FF_03FF_03FF;
  localparam logic [63:0] Q_OVER = 64'h0400_0400_0400_0400;
  localparam logic [63:0] Q_MIX  = 64'h03FF_0400_03FF_0400;
  localparam logic [63:0] Q_ODD  = 64'h0155_02AA_0001_03FE;

  localparam logic [255:0] W_ZERO = '0;
  localparam logic [255:0] W_ONES = '1;
  localparam logic [255:0] W_TOP  = {4{Q_TOP}};
  localparam logic [255:0] W_OVER = {4{Q_OVER}};
  localparam logic [255:0] W_MIX  = {4{Q_MIX}};
  localparam logic [255:0] W_ODD  = {4{Q_ODD}};
  // lane n carries code n
  localparam logic [255:0] W_IDX  = {64'h000F_000E_000D_000C, 64'h000B_000A_0009_0008,
                                     64'h0007_0006_0005_0004, 64'h0003_0002_0001_0000};

  localparam int DIR_N = 24;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{plch_pkg::CMD_READ, W_ZERO, 10'd0,    KNOWN, 36'd0,  1'b0},
    '{plch_pkg::CMD_READ, W_ZERO, 10'd1023, KNOWN, 36'd0,  1'b0},
    '{plch_pkg::CMD_ADD,  W_ZERO, 10'h3FF,  PRED,  36'd0,  1'b0},
    '{plch_pkg::CMD_READ, W_ZERO, 10'd0,    KNOWN, 36'd16, 1'b0},
    '{plch_pkg::CMD_READ, W_ZERO, 10'd0,    KNOWN, 36'd0,  1'b0},
    '{plch_pkg::CMD_ADD,  W_TOP,  10'd0,    PRED,  36'd0,  1'b0},
    '{plch_pkg::CMD_ADD,  W_TOP,  10'd0,    PRED,  36'd0,  1'b0},
    '{plch_pkg::CMD_READ, W_ONES, 10'd1023, KNOWN, 36'd32, 1'b0},
    '{plch_pkg::CMD_ADD,  W_IDX,  10'd5,    PRED,  36'd0,  1'b0},
    '{plch_pkg::CMD_READ, W_ZERO, 10'd5,    KNOWN, 36'd1,  1'b0},
    '{plch_pkg::CMD_READ, W_ZERO, 10'd0,    KNOWN, 36'd1,  1'b0},
    '{plch_pkg::CMD_READ, W_ZERO, 10'd15,   KNOWN, 36'd1,  1'b0},
    '{plch_pkg::CMD_ADD,  W_ONES, 10'd0,    PRED,  36'd0,  1'b0},
    '{plch_pkg::CMD_READ, W_ZERO, 10'd1023, KNOWN, 36'd0,  1'b1},
    '{plch_pkg::CMD_ADD,  W_OVER, 10'd0,    PRED,  36'd0,  1'b0},
    '{plch_pkg::CMD_ADD,  W_MIX,  10'd0,    PRED,  36'd0,  1'b0},
    '{plch_pkg::CMD_READ, W_ZERO, 10'd1023, KNOWN, 36'd8,  1'b1},
    '{plch_pkg::CMD_ADD,  W_IDX,  10'h2AA,  PRED,  36'd0,  1'b0},
    '{plch_pkg::CMD_ADD,  W_ZERO, 10'h155,  PRED,  36'd0,  1'b0},
    '{plch_pkg::CMD_READ, W_ONES, 10'd0,    PRED,  36'd0,  1'b0},
    '{plch_pkg::CMD_READ, W_ZERO, 10'd3,    PRED,  36'd0,  1'b0},
    '{plch_pkg::CMD_READ, W_ZERO, 10'd512,  KNOWN, 36'd0,  1'b1},
    '{plch_pkg::CMD_ADD,  W_ODD,  10'd0,    PRED,  36'd0,  1'b0},
    '{plch_pkg::CMD_READ, W_ZERO, 10'h155,  PRED,  36'd0,  1'b0}
  };

  // histogram mirror
  bit [COUNT_WIDTH-1:0] bin_count [LANES][BINS];
  bit                   code_overflow;
  bin_read_t            pending_totals [$];

  int mismatches;
  int n_adds;
  int n_reads;
  int n_wild_codes;
  int n_checked;
  int n_nonzero;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #12_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [SEL_WIDTH-1:0] hot_bin();
    int h;
    h = $urandom_range(0, 15);
    return (h < 8) ? SEL_WIDTH'(h) : SEL_WIDTH'(BINS - 16 + h);
  endfunction

  task automatic tally_word(input logic cmd, input logic [255:0] word,
                            input logic [SEL_WIDTH-1:0] sel,
                            input bit known, input bin_read_t given);
    bin_read_t             r;
    logic [CODE_WIDTH-1:0] code;
    if (cmd == plch_pkg::CMD_ADD) begin
      n_adds++;
      for (int n = 0; n < LANES; n++) begin
        code = word[n*CODE_WIDTH +: CODE_WIDTH];
        if (code >= BINS) begin
          code_overflow = 1'b1;
          n_wild_codes++;
        end else if (bin_count[n][code[SEL_WIDTH-1:0]] != '1) begin
          bin_count[n][code[SEL_WIDTH-1:0]]++;
        end
      end
    end else begin
      n_reads++;
      r.total = '0;
      for (int n = 0; n < LANES; n++) begin
        r.total += TOTAL_WIDTH'(bin_count[n][sel]);
        bin_count[n][sel] = '0;
      end
      r.err = code_overflow;
      if (r.total != 0) n_nonzero++;
      pending_totals.push_back(known ? given : r);
    end
  endtask

  // entered and left right after a falling edge
  task automatic send_word(input logic cmd, input logic [255:0] word,
                           input logic [SEL_WIDTH-1:0] sel,
                           input bit known, input bin_read_t given);
    int gap;
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_word_q0 <= word[63:0];
    in_word_q1 <= word[127:64];
    in_word_q2 <= word[191:128];
    in_word_q3 <= word[255:192];
    in_bin_sel <= sel;
    do @(posedge clk); while (in_stall);
    tally_word(cmd, word, sel, known, given);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_totals.size() != 0);
  endtask

  // result side: stall in bursts, with quiet stretches in between
  int stall_left;
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
  end
  always @(negedge clk) begin
    int r;
    if (stall_left == 0) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(1, 30);
      end else if (r < 88) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(1, 3);
      end else if (r < 97) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(4, 12);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(20, 60);
      end
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    bin_read_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_totals.size() == 0) begin
        $display("%0t: unexpected result, total %0d range_error %0b",
                 $time, out_bin_total, out_range_error);
        mismatches++;
      end else begin
        want = pending_totals.pop_front();
        n_checked++;
        if (out_bin_total !== want.total) begin
          $display("%0t: bin_total expected %0d, got %0d", $time, want.total, out_bin_total);
          mismatches++;
        end
        if (out_range_error !== want.err) begin
          $display("%0t: range_error expected %0b, got %0b",
                   $time, want.err, out_range_error);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [255:0]         word;
    logic [SEL_WIDTH-1:0] sel;
    logic                 cmd;
    bin_read_t            given;
    int                   style;
    int                   r;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_cmd     = plch_pkg::CMD_ADD;
    in_word_q0 = '0;
    in_word_q1 = '0;
    in_word_q2 = '0;
    in_word_q3 = '0;
    in_bin_sel = '0;
    mismatches = 0;
    n_adds = 0;
    n_reads = 0;
    n_wild_codes = 0;
    n_checked = 0;
    n_nonzero = 0;
    code_overflow = 1'b0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      given.total = DIR_ROWS[i].total;
      given.err   = DIR_ROWS[i].err;
      send_word(DIR_ROWS[i].cmd, DIR_ROWS[i].word, DIR_ROWS[i].sel,
                DIR_ROWS[i].known, given);
    end
    drain_results();

    given = '0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 700 || i == 1400) drain_results();
      if ($urandom_range(0, 99) < 35) begin
        // read: word fields are don't-care, fill them with noise
        cmd = plch_pkg::CMD_READ;
        for (int k = 0; k < 8; k++) word[k*32 +: 32] = $urandom;
        sel = ($urandom_range(0, 99) < 80) ? hot_bin() : SEL_WIDTH'($urandom_range(0, BINS - 1));
      end else begin
        cmd = plch_pkg::CMD_ADD;
        sel = SEL_WIDTH'($urandom);
        style = $urandom_range(0, 99);
        if (style < 8) begin
          for (int k = 0; k < 8; k++) word[k*32 +: 32] = $urandom;
        end else if (style < 20) begin
          word = {LANES{CODE_WIDTH'(hot_bin())}};
        end else begin
          for (int n = 0; n < LANES; n++) begin
            r = $urandom_range(0, 99);
            if (r < 85)
              word[n*CODE_WIDTH +: CODE_WIDTH] = CODE_WIDTH'(hot_bin());
            else if (r < 97)
              word[n*CODE_WIDTH +: CODE_WIDTH] = CODE_WIDTH'($urandom_range(0, BINS - 1));
            else
              word[n*CODE_WIDTH +: CODE_WIDTH] = CODE_WIDTH'($urandom);
          end
        end
      end
      send_word(cmd, word, sel, PRED, given);
    end

    drain_results();
    repeat (2 * LANES + 8) @(negedge clk);

    $display("covered %0d data words and %0d bin reads, %0d results checked",
             n_adds, n_reads, n_checked);
    $display("%0d reads returned a nonzero total, %0d lane codes were out of range",
             n_nonzero, n_wild_codes);
    if (mismatches == 0 && pending_totals.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
